@@ design/fragment_reassembly_tracker_core_defines.svh @@
// Assertion helpers shared by the fragment reassembly tracker RTL.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_CORE_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define FRT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define FRT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/frt_pkg.sv @@
`default_nettype none

package frt_pkg;

  localparam int SLOTS_DEF     = 4;
  localparam int FRAG_LIMIT    = 8;
  localparam int HDR_BYTES     = 4;
  localparam int MASK_W        = 8;
  localparam int TOTAL_W       = 4;
  localparam int CFG_ADDR_W    = 4;

  localparam logic [7:0]  MDPF_RESET = 8'd248;
  localparam logic [10:0] MFB_RESET  = 11'd1514;
  localparam logic [15:0] TMO_RESET  = 16'd1000;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_MDPF = 2'd0;
  localparam logic [1:0] CFG_MFB  = 2'd1;
  localparam logic [1:0] CFG_TMO  = 2'd2;

  localparam logic KIND_FRAG = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TOTAL_MIS = 3'd4;
  localparam logic [2:0] ST_DUPLICATE = 3'd5;
  localparam logic [2:0] ST_TICK_DONE = 3'd6;

  typedef struct packed {
    logic        kind;
    logic        last_flag;
    logic [7:0]  seq;
    logic [7:0]  total;
    logic [7:0]  frag_index;
    logic [15:0] frag_size;
    logic [31:0] now_ms;
  } frt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_index;
    logic [10:0] write_offset;
    logic [7:0]  payload_len;
    logic [10:0] frame_length;
    logic        deliver;
    logic        evicted;
    logic [2:0]  expired_count;
  } frt_out_t;

  typedef struct packed {
    logic               active;
    logic [7:0]         seq;
    logic [TOTAL_W-1:0] total;
    logic [MASK_W-1:0]  mask;
    logic [31:0]        start;
    logic [10:0]        length;
  } frt_slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SELECT,
    S_EVAL
  } frt_state_t;

endpackage

`default_nettype wire

@@ design/frt_slot_table.sv @@
`default_nettype none

module frt_slot_table #(
  parameter int SLOTS = frt_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IDX_W-1:0]  addr,
  input  wire logic              wr_en,
  input  wire frt_pkg::frt_slot_t wr_entry,
  output frt_pkg::frt_slot_t     rd_entry
);

  logic                       active_r [SLOTS];
  logic [frt_pkg::MASK_W-1:0] mask_r   [SLOTS];
  logic [7:0]                 seq_r    [SLOTS];
  logic [frt_pkg::TOTAL_W-1:0] total_r [SLOTS];
  logic [31:0]                start_r  [SLOTS];
  logic [10:0]                length_r [SLOTS];

  // Active flags and masks clear on reset; the rest is only read once a slot is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_r[i] <= 1'b0;
        mask_r[i]   <= '0;
      end
    end else if (wr_en) begin
      active_r[addr] <= wr_entry.active;
      mask_r[addr]   <= wr_entry.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seq_r[addr]    <= wr_entry.seq;
      total_r[addr]  <= wr_entry.total;
      start_r[addr]  <= wr_entry.start;
      length_r[addr] <= wr_entry.length;
    end
  end

  always_comb begin
    rd_entry.active = active_r[addr];
    rd_entry.seq    = seq_r[addr];
    rd_entry.total  = total_r[addr];
    rd_entry.mask   = mask_r[addr];
    rd_entry.start  = start_r[addr];
    rd_entry.length = length_r[addr];
  end

endmodule

`default_nettype wire

@@ design/fragment_reassembly_tracker_core.sv @@
`default_nettype none
// Fragment reassembly tracker: a transaction is accepted when start is high while busy is
// low, and busy stays high until its result appears. A header or payload-size reject
// ends in the check state, a tick after the slot scan, and a fragment after the scan,
// a select state that picks the slot and an eval state that updates it. The scan reads
// one slot per cycle through the single age subtractor and compare. The result is
// driven for exactly one cycle with out_valid, in the cycle busy falls; the receiver
// cannot stall it, so it must capture every strobe. A new transaction may start in
// that same cycle. No clearing pass is needed after reset.

`include "fragment_reassembly_tracker_core_defines.svh"

module fragment_reassembly_tracker_core #(
  parameter int SLOTS = frt_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int EXP_W = $clog2(SLOTS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire frt_pkg::frt_in_t              in_data,
  output logic                               out_valid,
  output frt_pkg::frt_out_t                  out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [frt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  frt_pkg::frt_state_t state_r, state_nxt;

  frt_pkg::frt_in_t  in_r;
  frt_pkg::frt_out_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [7:0]  mdpf_r;
  logic [10:0] mfb_r;
  logic [15:0] tmo_r;

  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [10:0]      off_r, off_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic             match_found_r, match_found_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [31:0]      best_r, best_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic             take_r, take_nxt;
  logic             evicted_r, evicted_nxt;
  logic [EXP_W-1:0] exp_cnt_r, exp_cnt_nxt;

  frt_pkg::frt_slot_t rd_entry, wr_entry;
  logic               wr_en;

  logic        accept;
  logic        scan_last;
  logic        hdr_bad;
  logic        len_bad;
  logic        pre_reject;
  logic [15:0] dlen16;
  logic [10:0] off_prod;
  logic [31:0] age;

  frt_slot_table #(.SLOTS(SLOTS)) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (ptr_r),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry)
  );

  assign busy      = (state_r != frt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign pready    = 1'b1;

  // Header checks run on the latched transaction in the check cycle.
  assign dlen16   = in_r.frag_size - 16'(frt_pkg::HDR_BYTES);
  assign hdr_bad  = (in_r.frag_size < 16'(frt_pkg::HDR_BYTES)) || (in_r.total == 8'd0) ||
                    (in_r.total > 8'(frt_pkg::FRAG_LIMIT)) ||
                    (in_r.frag_index >= in_r.total);
  assign len_bad  = dlen16 > {8'd0, mdpf_r};
  assign pre_reject = (in_r.kind == frt_pkg::KIND_FRAG) && (hdr_bad || len_bad);
  assign off_prod = {8'd0, in_r.frag_index[2:0]} * {3'd0, mdpf_r};
  assign age      = in_r.now_ms - rd_entry.start;
  assign scan_last = (ptr_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frt_pkg::S_IDLE: begin
        if (start) state_nxt = frt_pkg::S_CHECK;
      end
      frt_pkg::S_CHECK: begin
        state_nxt = pre_reject ? frt_pkg::S_IDLE : frt_pkg::S_SCAN;
      end
      frt_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = (in_r.kind == frt_pkg::KIND_TICK) ? frt_pkg::S_IDLE : frt_pkg::S_SELECT;
        end
      end
      frt_pkg::S_SELECT: begin
        state_nxt = frt_pkg::S_EVAL;
      end
      frt_pkg::S_EVAL: begin
        state_nxt = frt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = frt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [frt_pkg::TOTAL_W-1:0] eff_total;
    logic [frt_pkg::MASK_W-1:0]  eff_mask;
    logic [frt_pkg::MASK_W-1:0]  bit_sel;
    logic [frt_pkg::MASK_W-1:0]  new_mask;
    logic [8:0]                  full9;
    logic [11:0]                 end_sum;
    logic [10:0]                 new_len;
    logic                        range_bad;

    ptr_nxt         = ptr_r;
    off_nxt         = off_r;
    dlen_nxt        = dlen_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    best_nxt        = best_r;
    pick_nxt        = pick_r;
    take_nxt        = take_r;
    evicted_nxt     = evicted_r;
    exp_cnt_nxt     = exp_cnt_r;
    out_valid_nxt   = 1'b0;
    res_nxt         = res_r;
    wr_en           = 1'b0;
    wr_entry        = rd_entry;

    eff_total = take_r ? in_r.total[frt_pkg::TOTAL_W-1:0] : rd_entry.total;
    eff_mask  = take_r ? '0 : rd_entry.mask;
    bit_sel   = frt_pkg::MASK_W'(1) << in_r.frag_index[2:0];
    new_mask  = eff_mask | bit_sel;
    full9     = (9'd1 << eff_total) - 9'd1;
    end_sum   = {1'b0, off_r} + {4'd0, dlen_r};
    range_bad = (off_r > mfb_r) || (end_sum > {1'b0, mfb_r});
    new_len   = in_r.last_flag ? end_sum[10:0] : (take_r ? 11'd0 : rd_entry.length);

    unique case (state_r)
      frt_pkg::S_IDLE: begin
      end
      frt_pkg::S_CHECK: begin
        ptr_nxt         = '0;
        off_nxt         = off_prod;
        dlen_nxt        = dlen16[7:0];
        match_found_nxt = 1'b0;
        free_found_nxt  = 1'b0;
        best_nxt        = '0;
        pick_nxt        = '0;
        exp_cnt_nxt     = '0;
        if (pre_reject) begin
          out_valid_nxt  = 1'b1;
          res_nxt        = '0;
          res_nxt.status = hdr_bad ? frt_pkg::ST_BAD_HDR : frt_pkg::ST_BAD_LEN;
        end
      end
      frt_pkg::S_SCAN: begin
        if (!scan_last) ptr_nxt = ptr_r + IDX_W'(1);
        if (in_r.kind == frt_pkg::KIND_TICK) begin
          if (rd_entry.active && (age >= {16'd0, tmo_r})) begin
            wr_en           = 1'b1;
            wr_entry.active = 1'b0;
            wr_entry.mask   = '0;
            exp_cnt_nxt     = exp_cnt_r + EXP_W'(1);
          end
          if (scan_last) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
            res_nxt.status = frt_pkg::ST_TICK_DONE;
            res_nxt.expired_count = 3'(exp_cnt_nxt);
          end
        end else begin
          if (!match_found_r && rd_entry.active && (rd_entry.seq == in_r.seq)) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = ptr_r;
          end
          if (!free_found_r && !rd_entry.active) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = ptr_r;
          end
          // Strictly larger age wins, so the lowest slot keeps a tie.
          if (age > best_r) begin
            best_nxt = age;
            pick_nxt = ptr_r;
          end
        end
      end
      frt_pkg::S_SELECT: begin
        take_nxt    = !match_found_r;
        evicted_nxt = !match_found_r && !free_found_r;
        if (match_found_r) begin
          ptr_nxt = match_idx_r;
        end else if (free_found_r) begin
          ptr_nxt = free_idx_r;
        end else begin
          ptr_nxt = pick_r;
        end
      end
      frt_pkg::S_EVAL: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_entry.active = 1'b1;
          wr_entry.seq    = in_r.seq;
          wr_entry.total  = in_r.total[frt_pkg::TOTAL_W-1:0];
          wr_entry.mask   = '0;
          wr_entry.start  = in_r.now_ms;
          wr_entry.length = 11'd0;
        end
        out_valid_nxt      = 1'b1;
        res_nxt            = '0;
        res_nxt.slot_index = 2'(ptr_r);
        res_nxt.evicted    = evicted_r;
        if (in_r.total != {4'd0, eff_total}) begin
          wr_entry.active = 1'b0;
          wr_entry.mask   = '0;
          res_nxt.status  = frt_pkg::ST_TOTAL_MIS;
        end else if (range_bad) begin
          res_nxt.status = frt_pkg::ST_BAD_LEN;
        end else if ((eff_mask & bit_sel) != '0) begin
          res_nxt.status = frt_pkg::ST_DUPLICATE;
        end else begin
          res_nxt.write_offset = off_r;
          res_nxt.payload_len  = dlen_r;
          wr_entry.length      = new_len;
          if (new_mask == full9[frt_pkg::MASK_W-1:0]) begin
            wr_entry.active      = 1'b0;
            wr_entry.mask        = '0;
            res_nxt.status       = frt_pkg::ST_COMPLETE;
            res_nxt.frame_length = new_len;
            res_nxt.deliver      = (new_len != 11'd0);
          end else begin
            wr_entry.mask  = new_mask;
            res_nxt.status = frt_pkg::ST_STORED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      mdpf_r      <= frt_pkg::MDPF_RESET;
      mfb_r       <= frt_pkg::MFB_RESET;
      tmo_r       <= frt_pkg::TMO_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          frt_pkg::CFG_MDPF: mdpf_r <= pwdata[7:0];
          frt_pkg::CFG_MFB:  mfb_r  <= pwdata[10:0];
          frt_pkg::CFG_TMO:  tmo_r  <= pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
    res_r         <= res_nxt;
    ptr_r         <= ptr_nxt;
    off_r         <= off_nxt;
    dlen_r        <= dlen_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    best_r        <= best_nxt;
    pick_r        <= pick_nxt;
    take_r        <= take_nxt;
    evicted_r     <= evicted_nxt;
    exp_cnt_r     <= exp_cnt_nxt;
  end

  always_comb begin
    unique case (paddr[3:2])
      frt_pkg::CFG_MDPF: prdata = {24'd0, mdpf_r};
      frt_pkg::CFG_MFB:  prdata = {21'd0, mfb_r};
      frt_pkg::CFG_TMO:  prdata = {16'd0, tmo_r};
      default:           prdata = 32'd0;
    endcase
  end

  `FRT_ASSERT_IMP(a_result_when_idle, clk, rst_n, out_valid, !busy, "result strobe while busy")
  `FRT_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy, "accepted transaction not busy")
  `FRT_ASSERT_IMP(a_deliver_complete, clk, rst_n, out_valid && out_data.deliver, (out_data.status == frt_pkg::ST_COMPLETE) && (out_data.frame_length != 11'd0), "deliver without a complete frame")
  `FRT_ASSERT_IMP(a_tick_clean, clk, rst_n, out_valid && (out_data.status == frt_pkg::ST_TICK_DONE), (out_data.slot_index == 2'd0) && !out_data.evicted, "tick result names a slot")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import frt_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;

  class reassembly_scoreboard;
    logic [7:0]  max_data;
    logic [10:0] max_frame;
    logic [15:0] timeout;

    bit          slot_busy [NSLOT];
    logic [7:0]  slot_seq [NSLOT];
    logic [3:0]  slot_total [NSLOT];
    logic [7:0]  slot_mask [NSLOT];
    logic [31:0] slot_born [NSLOT];
    logic [10:0] slot_len [NSLOT];

    frt_out_t expected_results[$];
    int errors;
    int accepted;
    int checked;
    int evictions;
    int expirations;
    int status_count[8];

    function new();
      max_data  = MDPF_RESET;
      max_frame = MFB_RESET;
      timeout   = TMO_RESET;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        CFG_MDPF: max_data = value[7:0];
        CFG_MFB: max_frame = value[10:0];
        CFG_TMO: timeout = value[15:0];
        default: ;
      endcase
    endfunction

    function void claim_slot(int s, frt_in_t x);
      slot_busy[s]  = 1'b1;
      slot_seq[s]   = x.seq;
      slot_total[s] = x.total[3:0];
      slot_mask[s]  = '0;
      slot_born[s]  = x.now_ms;
      slot_len[s]   = '0;
    endfunction

    function frt_out_t predict_fragment_result(frt_in_t x);
      frt_out_t r;
      int unsigned dlen;
      int unsigned off;
      logic [31:0] age;
      logic [31:0] best;
      logic [8:0] full;
      int s;
      r = '0;
      if (x.kind == KIND_TICK) begin
        for (int i = 0; i < NSLOT; i++) begin
          age = x.now_ms - slot_born[i];
          if (slot_busy[i] && age >= timeout) begin
            slot_busy[i] = 1'b0;
            slot_mask[i] = '0;
            r.expired_count++;
          end
        end
        r.status = ST_TICK_DONE;
      end else if (x.frag_size < HDR_BYTES || x.total == 0 || x.total > FRAG_LIMIT ||
                   x.frag_index >= x.total) begin
        r.status = ST_BAD_HDR;
      end else if (x.frag_size - HDR_BYTES > max_data) begin
        r.status = ST_BAD_LEN;
      end else begin
        dlen = x.frag_size - HDR_BYTES;
        off = x.frag_index * max_data;
        s = -1;
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && slot_busy[i] && slot_seq[i] == x.seq) s = i;
        if (s < 0) begin
          for (int i = 0; i < NSLOT; i++)
            if (s < 0 && !slot_busy[i]) s = i;
          if (s < 0) begin
            // The strictly oldest slot goes; equal ages leave the lowest such slot as the victim.
            best = '0;
            s = 0;
            for (int i = 0; i < NSLOT; i++) begin
              age = x.now_ms - slot_born[i];
              if (age > best) begin
                best = age;
                s = i;
              end
            end
            r.evicted = 1'b1;
          end
          claim_slot(s, x);
        end
        r.slot_index = s[1:0];
        if (x.total != slot_total[s]) begin
          slot_busy[s] = 1'b0;
          slot_mask[s] = '0;
          r.status = ST_TOTAL_MIS;
        end else if (off > max_frame || dlen > max_frame - off) begin
          r.status = ST_BAD_LEN;
        end else if (slot_mask[s][x.frag_index[2:0]]) begin
          r.status = ST_DUPLICATE;
        end else begin
          slot_mask[s][x.frag_index[2:0]] = 1'b1;
          if (x.last_flag) slot_len[s] = 11'(off + dlen);
          r.write_offset = off[10:0];
          r.payload_len = dlen[7:0];
          full = (9'd1 << slot_total[s]) - 9'd1;
          if (slot_mask[s] == full[7:0]) begin
            r.status = ST_COMPLETE;
            r.frame_length = slot_len[s];
            r.deliver = (slot_len[s] != 0);
            slot_busy[s] = 1'b0;
            slot_mask[s] = '0;
          end else begin
            r.status = ST_STORED;
          end
        end
      end
      return r;
    endfunction

    function void note_input(frt_in_t x);
      frt_out_t r;
      r = predict_fragment_result(x);
      accepted++;
      status_count[r.status]++;
      evictions += r.evicted;
      expirations += r.expired_count;
      expected_results.push_back(r);
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(frt_out_t got);
      frt_out_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no pending transaction, actual %p", $time, got);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (got.status !== e.status) mismatch("status", e.status, got.status);
      if (got.slot_index !== e.slot_index) mismatch("slot_index", e.slot_index, got.slot_index);
      if (got.write_offset !== e.write_offset)
        mismatch("write_offset", e.write_offset, got.write_offset);
      if (got.payload_len !== e.payload_len)
        mismatch("payload_len", e.payload_len, got.payload_len);
      if (got.frame_length !== e.frame_length)
        mismatch("frame_length", e.frame_length, got.frame_length);
      if (got.deliver !== e.deliver) mismatch("deliver", e.deliver, got.deliver);
      if (got.evicted !== e.evicted) mismatch("evicted", e.evicted, got.evicted);
      if (got.expired_count !== e.expired_count)
        mismatch("expired_count", e.expired_count, got.expired_count);
    endfunction
  endclass

  typedef struct {
    int max_data;
    int max_frame;
    int timeout;
    int idle_pct;
    int items;
  } phase_plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  frt_in_t in_data = '0;
  logic out_valid;
  frt_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  reassembly_scoreboard sb;
  frt_in_t frame_q[3][$];
  logic [31:0] ms_now;
  int quiet_cycles = 0;
  int settings_used = 1;

  phase_plan_t plan[6] = '{
    '{248, 1514, 1000, 0, 180},
    '{255, 2047, 65535, 73, 150},
    '{1, 1, 1, 8, 130},
    '{100, 600, 0, 0, 130},
    '{37, 2047, 300, 73, 130},
    '{248, 1514, 1000, 8, 130}
  };

  always #10 clk = ~clk;

  fragment_reassembly_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Every strobed result is consumed at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic frt_in_t make_item(logic kind, logic last, logic [7:0] seq,
                                        logic [7:0] total, logic [7:0] idx,
                                        logic [15:0] len, logic [31:0] now);
    frt_in_t x;
    x.kind = kind;
    x.last_flag = last;
    x.seq = seq;
    x.total = total;
    x.frag_index = idx;
    x.frag_size = len;
    x.now_ms = now;
    return x;
  endfunction

  function automatic frt_in_t noise_item();
    frt_in_t x;
    x.kind = 1'($urandom_range(1));
    x.last_flag = 1'($urandom_range(1));
    x.seq = 8'($urandom_range(255));
    x.total = ($urandom_range(1)) ? 8'($urandom_range(255)) : 8'($urandom_range(9));
    x.frag_index = ($urandom_range(1)) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
    x.frag_size = 16'($urandom_range(65535));
    x.now_ms = ($urandom_range(1)) ? ms_now : $urandom;
    return x;
  endfunction

  // Queues one frame's fragments in shuffled order, with the odd drop, repeat, oversized
  // fragment, wrong total or misplaced last flag.
  function automatic void build_frame(int f);
    int n;
    int k;
    int tmp;
    int order[8];
    logic [7:0] fseq;
    frt_in_t x;
    fseq = ($urandom_range(99) < 80) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    n = $urandom_range(1, FRAG_LIMIT);
    for (int j = 0; j < n; j++) order[j] = j;
    for (int j = n - 1; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (int j = 0; j < n; j++) begin
      if (n > 1 && $urandom_range(99) < 3) continue;
      x = make_item(KIND_FRAG, 1'b0, fseq, 8'(n), 8'(order[j]), '0, '0);
      x.last_flag = (order[j] == n - 1) ^ ($urandom_range(99) < 4);
      if ($urandom_range(99) < 92) begin
        x.frag_size = 16'(HDR_BYTES + $urandom_range(sb.max_data));
      end else begin
        x.frag_size = 16'(HDR_BYTES + sb.max_data + $urandom_range(1, 400));
      end
      if ($urandom_range(99) < 4) x.total = 8'($urandom_range(1, FRAG_LIMIT));
      frame_q[f].push_back(x);
      if ($urandom_range(99) < 4) frame_q[f].push_back(x);
    end
  endfunction

  function automatic frt_in_t next_item();
    int r;
    int f;
    frt_in_t x;
    r = $urandom_range(99);
    if ($urandom_range(99) < 2) begin
      ms_now = ms_now + $urandom;
    end else begin
      ms_now = ms_now + 32'($urandom_range(80));
    end
    if (r < 8) begin
      x = make_item(KIND_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), ms_now);
    end else if (r < 20) begin
      x = noise_item();
    end else begin
      f = $urandom_range(2);
      while (frame_q[f].size() == 0) build_frame(f);
      x = frame_q[f].pop_front();
      x.now_ms = ms_now;
    end
    return x;
  endfunction

  task automatic send(frt_in_t x);
    start <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_input(x);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    in_data <= noise_item();
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send(make_item(KIND_FRAG, 1'b0, 8'd0, 8'd1, 8'd0, 16'd3, 32'd10));
    send(make_item(KIND_FRAG, 1'b0, 8'd0, 8'd0, 8'd0, 16'd20, 32'd20));
    send(make_item(KIND_FRAG, 1'b1, 8'd255, 8'd9, 8'd0, 16'd20, 32'd30));
    send(make_item(KIND_FRAG, 1'b0, 8'd5, 8'd3, 8'd3, 16'd20, 32'd40));
    send(make_item(KIND_FRAG, 1'b0, 8'd5, 8'd255, 8'd255, 16'hFFFF, 32'd50));
    send(make_item(KIND_FRAG, 1'b0, 8'd6, 8'd2, 8'd0, 16'd253, 32'd60));
    send(make_item(KIND_FRAG, 1'b0, 8'd6, 8'd8, 8'd1, 16'hFFFF, 32'd70));
    send(make_item(KIND_FRAG, 1'b1, 8'd1, 8'd1, 8'd0, 16'd252, 32'd100));
    // A one-fragment frame without its last flag completes with no length.
    send(make_item(KIND_FRAG, 1'b0, 8'd2, 8'd1, 8'd0, 16'd4, 32'd110));
    send(make_item(KIND_FRAG, 1'b0, 8'd3, 8'd2, 8'd0, 16'd100, 32'd120));
    send(make_item(KIND_FRAG, 1'b0, 8'd3, 8'd2, 8'd0, 16'd100, 32'd130));
    send(make_item(KIND_FRAG, 1'b0, 8'd3, 8'd3, 8'd1, 16'd50, 32'd140));
    send(make_item(KIND_FRAG, 1'b1, 8'd4, 8'd8, 8'd7, 16'd252, 32'd150));
    send(make_item(KIND_FRAG, 1'b0, 8'd255, 8'd8, 8'd0, 16'd4, 32'd160));
    send(make_item(KIND_FRAG, 1'b0, 8'd9, 8'd4, 8'd2, 16'd200, 32'd170));
    send(make_item(KIND_FRAG, 1'b0, 8'd10, 8'd4, 8'd1, 16'd200, 32'd180));
    send(make_item(KIND_FRAG, 1'b0, 8'd11, 8'd2, 8'd0, 16'd30, 32'd1500));
    send(make_item(KIND_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    // Four slots born together, so the eviction that follows falls on slot 0.
    for (int i = 0; i < 5; i++)
      send(make_item(KIND_FRAG, 1'b0, 8'(20 + i), 8'd2, 8'(i / 4), 16'd10, 32'd5000));
    send(make_item(KIND_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 16'd0, 32'd5999));
    send(make_item(KIND_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 16'd0, 32'd6000));
  endtask

  initial begin
    sb = new();
    ms_now = 32'd10000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        write_reg(CFG_MDPF, 32'(plan[p].max_data));
        write_reg(CFG_MFB, 32'(plan[p].max_frame));
        write_reg(CFG_TMO, 32'(plan[p].timeout));
        settings_used++;
      end else begin
        run_directed();
      end
      for (int k = 0; k < plan[p].items; k++) begin
        send(next_item());
        if ($urandom_range(99) < plan[p].idle_pct) begin
          pause($urandom_range(1, 8));
        end else if ($urandom_range(199) == 0) begin
          drain();
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
      sb.errors++;
    end

    $display("Ran %0d transactions under %0d register settings, %0d results checked.",
             sb.accepted, settings_used, sb.checked);
    $display("Stored %0d, complete %0d, bad header %0d, bad length %0d, total mismatch %0d, %s",
             sb.status_count[ST_STORED], sb.status_count[ST_COMPLETE],
             sb.status_count[ST_BAD_HDR], sb.status_count[ST_BAD_LEN],
             sb.status_count[ST_TOTAL_MIS],
             $sformatf("duplicate %0d, ticks %0d, evictions %0d, expired slots %0d.",
                       sb.status_count[ST_DUPLICATE], sb.status_count[ST_TICK_DONE],
                       sb.evictions, sb.expirations));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
